[hdl/obj_face_fan_triangulator_unit_assert.svh]
// Assertion macros shared by the face fan triangulator RTL.
// Depends on nothing; included by the top level.
`ifndef OBJ_FACE_FAN_TRIANGULATOR_UNIT_ASSERT_SVH
`define OBJ_FACE_FAN_TRIANGULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define OFAN_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ofan: same-cycle implication violated");

// Next-cycle implication, always active (used to check reset behavior).
`define OFAN_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ofan: next-cycle implication violated");

`endif

[hdl/ofan_pkg.sv]
// Shared types and constants of the face fan triangulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ofan_pkg;

    localparam int MAX_CORNERS = 1000;
    localparam int CNT_W       = $clog2(MAX_CORNERS + 1);

    // command queue between front and back, depth must be a power of two
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] corner_a;
        logic signed [31:0] corner_b;
        logic signed [31:0] corner_c;
        logic               face_last;
    } t_result;

    typedef enum logic [2:0] {
        BC_NEWLINE,
        BC_SPACE,
        BC_LEAD_WS,
        BC_PLUS,
        BC_MINUS,
        BC_DIGIT,
        BC_F,
        BC_OTHER
    } t_byte_class;

    typedef struct packed {
        t_byte_class cls;
        logic [3:0]  digit;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef enum logic [1:0] {
        LM_START,
        LM_SKIP,
        LM_HEAD,
        LM_TOKENS
    } t_line_mode;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_DONE
    } t_phase;

endpackage

`default_nettype wire

[hdl/obj_face_fan_triangulator_unit.sv]
// OBJ face fan triangulator, byte-stream in, triangle stream out.
// Input channel: push/full carry one text byte plus a stream_end flag per item.
// Output channel: empty/pop carry one fan triangle per item; corners are the
//   face indices minus one, face_last marks the triangle closed by the line end or stream end.
// Throughput: one byte per clock while the receiver keeps popping. The front end
//   classifies each byte into a four-entry command queue; the back end runs the
//   line/token state machine on one command per cycle unless a full result queue
//   holds it, and writes triangles to that two-entry result queue.
// A byte that completes a triangle is registered in the command queue, then the
//   triangle is registered in the result queue, where it clears empty.
// Receiver stall: the result queue fills, the back end holds, then the command
//   queue fills and full rises; no item is lost or repeated.
// Reset (synchronous, active low): both queues empty, line state back to the
//   start of a line. No clearing pass is needed.
// Depends on ofan_pkg, ofan_front, ofan_back and the assertion macro header.
`default_nettype none
`include "obj_face_fan_triangulator_unit_assert.svh"

module obj_face_fan_triangulator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  ofan_pkg::t_in_item  i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output ofan_pkg::t_result   o_result
);
    import ofan_pkg::*;

    t_cmd_link w_link;
    logic      w_take;

    ofan_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_link  (w_link),
        .i_take  (w_take)
    );

    ofan_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_link),
        .o_take   (w_take),
        .o_result (o_result),
        .o_empty  (empty),
        .i_pop    (pop)
    );

    // the command queue only fills while a finished triangle is waiting
    `OFAN_ASSERT_IMPLY(a_full_has_result, i_clk, i_rst_n, full, !empty)
    // back end stalls only when results are waiting
    `OFAN_ASSERT_IMPLY(a_stall_has_result, i_clk, i_rst_n, w_link.valid && !w_take, !empty)
    `OFAN_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, empty && !full)

endmodule

`default_nettype wire

[hdl/ofan_front.sv]
// Front end: classifies each accepted byte and queues it for the back end.
// Depends on ofan_pkg.
`default_nettype none

module ofan_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ofan_pkg::t_in_item    i_item,
    output logic                  o_full,
    output ofan_pkg::t_cmd_link   o_link,
    input  logic                  i_take
);
    import ofan_pkg::*;

    t_cmd             w_cmd;
    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr;
    logic [CQ_AW-1:0] r_rd;
    logic [CQ_AW:0]   r_count;
    logic [CQ_AW-1:0] n_wr;
    logic [CQ_AW-1:0] n_rd;
    logic [CQ_AW:0]   n_count;
    logic             w_push_fire;
    logic             w_pop_fire;

    // byte classifier
    always_comb begin
        w_cmd.last  = i_item.stream_end;
        w_cmd.digit = i_item.data_byte[3:0];
        if (i_item.data_byte == CH_NL) begin
            w_cmd.cls = BC_NEWLINE;
        end else if (i_item.data_byte == CH_SPACE) begin
            w_cmd.cls = BC_SPACE;
        end else if (i_item.data_byte >= CH_TAB && i_item.data_byte <= CH_CR) begin
            w_cmd.cls = BC_LEAD_WS;
        end else if (i_item.data_byte == CH_PLUS) begin
            w_cmd.cls = BC_PLUS;
        end else if (i_item.data_byte == CH_MINUS) begin
            w_cmd.cls = BC_MINUS;
        end else if (i_item.data_byte >= CH_ZERO && i_item.data_byte <= CH_NINE) begin
            w_cmd.cls = BC_DIGIT;
        end else if (i_item.data_byte == CH_F) begin
            w_cmd.cls = BC_F;
        end else begin
            w_cmd.cls = BC_OTHER;
        end
    end

    assign o_full      = (r_count == (CQ_AW + 1)'(CQ_DEPTH));
    assign w_push_fire = i_push && !o_full;
    assign w_pop_fire  = i_take && (r_count != '0);

    assign o_link.valid = (r_count != '0);
    assign o_link.cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = w_push_fire ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop_fire ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (w_push_fire && !w_pop_fire) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_fire && w_pop_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_fire) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/ofan_back.sv]
// Back end: line/token state machine, fan triangle generation, result queue.
// Depends on ofan_pkg.
`default_nettype none

module ofan_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ofan_pkg::t_cmd_link   i_link,
    output logic                  o_take,
    output ofan_pkg::t_result     o_result,
    output logic                  o_empty,
    input  logic                  i_pop
);
    import ofan_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CORNERS);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_CORNERS - 2);
    localparam logic [CNT_W-1:0] CNT_TRI = CNT_W'(2);

    t_cmd               w_cmd;
    t_line_mode         r_mode;
    t_line_mode         n_mode;
    t_phase             r_phase;
    t_phase             n_phase;
    logic               r_neg;
    logic               n_neg;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   w_cnt_inc;
    // token value and token value minus one are kept side by side
    logic signed [31:0] r_acc;
    logic signed [31:0] n_acc;
    logic signed [31:0] r_accm1;
    logic signed [31:0] n_accm1;
    logic signed [31:0] r_apex_m1;
    logic signed [31:0] n_apex_m1;
    logic signed [31:0] r_prior_m1;
    logic signed [31:0] n_prior_m1;
    logic signed [31:0] w_acc10;
    logic signed [5:0]  w_sd;
    logic signed [5:0]  w_sdm1;
    logic signed [31:0] w_feed;
    logic signed [31:0] w_feedm1;
    logic               w_tok;
    logic               w_fin;
    logic               w_tok_after;
    logic               w_emit;
    t_result            w_res;

    t_result            r_rq [2];
    logic               r_rq_wr;
    logic               r_rq_rd;
    logic [1:0]         r_rq_cnt;
    logic [1:0]         n_rq_cnt;
    logic               w_rq_full;
    logic               w_rq_pop;
    logic               w_rq_push;

    assign w_cmd     = i_link.cmd;
    assign w_rq_full = (r_rq_cnt == 2'd2);
    assign w_rq_pop  = i_pop && (r_rq_cnt != 2'd0);
    assign o_take    = i_link.valid && (!w_rq_full || w_rq_pop);
    assign w_rq_push = o_take && w_emit;
    assign o_empty   = (r_rq_cnt == 2'd0);
    assign o_result  = r_rq[r_rq_rd];

    // digit accumulate: acc*10 + signed digit, both for value and value-1
    assign w_acc10  = (r_acc <<< 3) + (r_acc <<< 1);
    assign w_sd     = r_neg ? -$signed({2'b00, w_cmd.digit}) : $signed({2'b00, w_cmd.digit});
    assign w_sdm1   = w_sd - 6'sd1;
    assign w_feed   = w_acc10 + {{26{w_sd[5]}}, w_sd};
    assign w_feedm1 = w_acc10 + {{26{w_sdm1[5]}}, w_sdm1};

    assign w_cnt_inc = (r_count < CNT_MAX) ? r_count + 1'b1 : r_count;

    // next line mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            LM_START: begin
                if (w_cmd.cls == BC_F) begin
                    n_mode = LM_HEAD;
                end else if (w_cmd.cls != BC_NEWLINE) begin
                    n_mode = LM_SKIP;
                end
            end
            LM_SKIP: begin
                if (w_cmd.cls == BC_NEWLINE) begin
                    n_mode = LM_START;
                end
            end
            LM_HEAD: begin
                if (w_cmd.cls == BC_SPACE) begin
                    n_mode = LM_TOKENS;
                end else if (w_cmd.cls == BC_NEWLINE) begin
                    n_mode = LM_START;
                end
            end
            LM_TOKENS: begin
                if (w_cmd.cls == BC_NEWLINE) begin
                    n_mode = LM_START;
                end
            end
            default: n_mode = LM_START;
        endcase
        if (w_cmd.last) begin
            n_mode = LM_START;
        end
    end

    // token datapath and result
    always_comb begin
        n_acc      = r_acc;
        n_accm1    = r_accm1;
        n_neg      = r_neg;
        n_phase    = r_phase;
        n_count    = r_count;
        n_apex_m1  = r_apex_m1;
        n_prior_m1 = r_prior_m1;
        w_emit     = 1'b0;
        w_res      = '0;

        w_tok = (r_mode == LM_TOKENS);
        w_fin = w_tok && (w_cmd.cls == BC_NEWLINE ||
                          (w_cmd.cls == BC_SPACE && r_count < CNT_CAP));
        w_tok_after = (w_tok && w_cmd.cls != BC_NEWLINE) ||
                      (r_mode == LM_HEAD && w_cmd.cls == BC_SPACE);

        if (w_fin) begin
            if (r_count == '0) begin
                n_apex_m1 = r_accm1;
            end
            if (r_count >= CNT_TRI) begin
                w_emit          = 1'b1;
                w_res.corner_a  = r_apex_m1;
                w_res.corner_b  = r_prior_m1;
                w_res.corner_c  = r_accm1;
                w_res.face_last = (w_cmd.cls == BC_NEWLINE);
            end
            n_prior_m1 = r_accm1;
            n_count    = (w_cmd.cls == BC_NEWLINE) ? '0 : w_cnt_inc;
            n_acc      = '0;
            n_accm1    = -32'sd1;
            n_neg      = 1'b0;
            n_phase    = PH_LEAD;
        end else if (w_tok) begin
            case (r_phase)
                PH_LEAD: begin
                    if (w_cmd.cls inside {BC_SPACE, BC_LEAD_WS}) begin
                        n_phase = PH_LEAD;
                    end else if (w_cmd.cls == BC_PLUS) begin
                        n_phase = PH_DIGITS;
                    end else if (w_cmd.cls == BC_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_DIGITS;
                    end else if (w_cmd.cls == BC_DIGIT) begin
                        n_acc   = w_feed;
                        n_accm1 = w_feedm1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (w_cmd.cls == BC_DIGIT) begin
                        n_acc   = w_feed;
                        n_accm1 = w_feedm1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end

        // stream end closes the open token, one result per item at most
        if (w_cmd.last) begin
            if (w_tok_after && !w_emit && n_count >= CNT_TRI) begin
                w_emit          = 1'b1;
                w_res.corner_a  = n_apex_m1;
                w_res.corner_b  = n_prior_m1;
                w_res.corner_c  = n_accm1;
                w_res.face_last = 1'b1;
            end
            n_count = '0;
            n_acc   = '0;
            n_accm1 = -32'sd1;
            n_neg   = 1'b0;
            n_phase = PH_LEAD;
        end
    end

    always_comb begin
        n_rq_cnt = r_rq_cnt;
        if (w_rq_push && !w_rq_pop) begin
            n_rq_cnt = r_rq_cnt + 2'd1;
        end else if (!w_rq_push && w_rq_pop) begin
            n_rq_cnt = r_rq_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rq_push) begin
            r_rq[r_rq_wr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= LM_START;
            r_phase    <= PH_LEAD;
            r_neg      <= 1'b0;
            r_count    <= '0;
            r_acc      <= '0;
            r_accm1    <= -32'sd1;
            r_apex_m1  <= -32'sd1;
            r_prior_m1 <= -32'sd1;
            r_rq_wr    <= 1'b0;
            r_rq_rd    <= 1'b0;
            r_rq_cnt   <= 2'd0;
        end else begin
            if (o_take) begin
                r_mode     <= n_mode;
                r_phase    <= n_phase;
                r_neg      <= n_neg;
                r_count    <= n_count;
                r_acc      <= n_acc;
                r_accm1    <= n_accm1;
                r_apex_m1  <= n_apex_m1;
                r_prior_m1 <= n_prior_m1;
            end
            if (w_rq_push) begin
                r_rq_wr <= ~r_rq_wr;
            end
            if (w_rq_pop) begin
                r_rq_rd <= ~r_rq_rd;
            end
            r_rq_cnt <= n_rq_cnt;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for obj_face_fan_triangulator_unit: feeds OBJ-like byte streams and
// checks every fan triangle against an in-bench line/token predictor.
// Depends on ofan_pkg and the unit RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ofan_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int RX_LONG_HOLD = 80;

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     push = 1'b0;
    logic     pop = 1'b0;
    logic     full;
    logic     empty;
    t_in_item byte_item = '0;
    t_result  tri_seen;

    obj_face_fan_triangulator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (byte_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (tri_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_in_item   send_q[$];
    t_result    triangles_due[$];
    logic [7:0] line_buf[$];
    int         err_count = 0;
    bit         calm_tail = 1'b0;
    int         tx_gap = 0;
    int         rx_gap = 0;
    int         rx_hold_ask = 0;
    int         rx_hold_seen = 0;
    int         rx_hold_left = 0;

    // ---------------- face fan predictor ----------------
    t_line_mode  fan_mode = LM_START;
    t_phase      tok_phase = PH_LEAD;
    logic [31:0] tok_value = '0;
    logic        tok_neg = 1'b0;
    logic [31:0] apex_val = '0;
    logic [31:0] prior_val = '0;
    int          corners_done = 0;

    function automatic void token_open();
        tok_value = '0;
        tok_neg   = 1'b0;
        tok_phase = PH_LEAD;
    endfunction

    function automatic void line_open();
        fan_mode     = LM_START;
        corners_done = 0;
        token_open();
    endfunction

    // atoi-style scan of one byte inside a token
    function automatic void token_feed(logic [7:0] b);
        logic is_digit;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        if (tok_phase == PH_LEAD) begin
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                tok_phase = PH_LEAD;
            end else if (b == CH_PLUS) begin
                tok_phase = PH_DIGITS;
            end else if (b == CH_MINUS) begin
                tok_neg   = 1'b1;
                tok_phase = PH_DIGITS;
            end else if (is_digit) begin
                tok_value = {24'd0, b - CH_ZERO};
                tok_phase = PH_DIGITS;
            end else begin
                tok_phase = PH_DONE;
            end
        end else if (tok_phase == PH_DIGITS) begin
            if (is_digit)
                tok_value = tok_value * 32'd10 + {24'd0, b - CH_ZERO};
            else
                tok_phase = PH_DONE;
        end
    endfunction

    function automatic void token_close(input logic last, output logic made,
                                        output t_result fan_tri);
        logic [31:0] v;
        v       = tok_neg ? (32'd0 - tok_value) : tok_value;
        made    = 1'b0;
        fan_tri = '0;
        if (corners_done == 0)
            apex_val = v;
        if (corners_done >= 2) begin
            fan_tri.corner_a  = apex_val - 32'd1;
            fan_tri.corner_b  = prior_val - 32'd1;
            fan_tri.corner_c  = v - 32'd1;
            fan_tri.face_last = last;
            made = 1'b1;
        end
        prior_val = v;
        if (corners_done < MAX_CORNERS)
            corners_done++;
        token_open();
    endfunction

    function automatic void fan_step(input t_in_item it);
        logic [7:0] b;
        logic       made;
        t_result    fan_tri;
        b       = it.data_byte;
        made    = 1'b0;
        fan_tri = '0;
        case (fan_mode)
            LM_START: begin
                if (b == CH_F)
                    fan_mode = LM_HEAD;
                else if (b != CH_NL)
                    fan_mode = LM_SKIP;
            end
            LM_SKIP: begin
                if (b == CH_NL)
                    line_open();
            end
            LM_HEAD: begin
                if (b == CH_SPACE) begin
                    fan_mode = LM_TOKENS;
                    token_open();
                end else if (b == CH_NL) begin
                    line_open();
                end
            end
            default: begin
                if (b == CH_NL) begin
                    token_close(1'b1, made, fan_tri);
                    line_open();
                end else if (b == CH_SPACE && corners_done < MAX_CORNERS - 2) begin
                    token_close(1'b0, made, fan_tri);
                end else begin
                    token_feed(b);
                end
            end
        endcase
        // stream end closes an open face line, unless this byte already gave a triangle
        if (it.stream_end) begin
            if (fan_mode == LM_TOKENS && !made)
                token_close(1'b1, made, fan_tri);
            line_open();
        end
        if (made)
            triangles_due.push_back(fan_tri);
    endfunction

    // ---------------- driver and monitors ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (tx_gap > 0) begin
            tx_gap--;
            push <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 2);
            push <= 1'b0;
        end else if (send_q.size() > 0) begin
            push      <= 1'b1;
            byte_item <= send_q[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold_ask != rx_hold_seen) begin
            rx_hold_seen = rx_hold_ask;
            rx_hold_left = RX_LONG_HOLD;
            pop <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        err_count++;
        $display("%0t ns: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                 $time, name, $signed(want), want, $signed(got), got);
    endtask

    always @(posedge i_clk) begin
        t_in_item dropped;
        t_result  want;
        if (i_rst_n && push && !full) begin
            fan_step(byte_item);
            dropped = send_q.pop_front();
        end
        if (i_rst_n && pop && !empty) begin
            if (triangles_due.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected triangle, expected none, got %0d %0d %0d %0b",
                         $time, tri_seen.corner_a, tri_seen.corner_b,
                         tri_seen.corner_c, tri_seen.face_last);
            end else begin
                want = triangles_due.pop_front();
                if (tri_seen.corner_a !== want.corner_a)
                    flag_field("corner_a", want.corner_a, tri_seen.corner_a);
                if (tri_seen.corner_b !== want.corner_b)
                    flag_field("corner_b", want.corner_b, tri_seen.corner_b);
                if (tri_seen.corner_c !== want.corner_c)
                    flag_field("corner_c", want.corner_c, tri_seen.corner_c);
                if (tri_seen.face_last !== want.face_last)
                    flag_field("face_last", {31'd0, want.face_last},
                               {31'd0, tri_seen.face_last});
            end
        end
    end

    // ---------------- stimulus builders ----------------
    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic put_number(input int unsigned v);
        put_text($sformatf("%0d", v));
    endtask

    // moves the built bytes to the send queue, stream_end optionally on the last one
    task automatic flush_line(input bit end_last, inout int spent);
        t_in_item it;
        for (int i = 0; i < line_buf.size(); i++) begin
            it.data_byte  = line_buf[i];
            it.stream_end = end_last && (i == line_buf.size() - 1);
            send_q.push_back(it);
        end
        spent += line_buf.size();
        line_buf.delete();
    endtask

    task automatic drain();
        while (send_q.size() != 0 || triangles_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic put_token();
        case ($urandom_range(0, 19))
            10: begin put_text("-"); put_number($urandom_range(0, 30)); end
            11: begin put_text("+"); put_number($urandom_range(0, 30)); end
            12: begin
                // large values, sometimes with an extra leading digit to force 32-bit wrap
                if ($urandom_range(0, 1)) put_text("9");
                put_number($urandom);
            end
            13: begin
                case ($urandom_range(0, 3))
                    0: put_byte(CH_TAB);
                    1: put_byte(CH_VT);
                    2: put_byte(CH_FF);
                    default: put_byte(CH_CR);
                endcase
                put_number($urandom_range(1, 30));
            end
            14: begin
                put_number($urandom_range(1, 30)); put_text("/");
                put_number($urandom_range(1, 30)); put_text("/");
                put_number($urandom_range(1, 30));
            end
            15: ;
            16: begin
                put_byte(8'($urandom_range(8'h21, 8'h7E)));
                put_number($urandom_range(0, 9));
            end
            17: put_text("0");
            18: begin put_number($urandom_range(1, 9)); put_byte(CH_TAB); put_text("4"); end
            19: begin
                if ($urandom_range(0, 1) != 0)
                    put_text("-");
                else
                    put_text("+-3");
            end
            default: put_number($urandom_range(1, 30));
        endcase
    endtask

    task automatic face_line(inout int spent);
        int n;
        int ending;
        if ($urandom_range(0, 7) == 0)
            put_text("fx ");
        else
            put_text("f ");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 7);
        for (int k = 0; k < n; k++) begin
            if (k > 0) put_byte(CH_SPACE);
            put_token();
        end
        ending = $urandom_range(0, 11);
        if (ending <= 6) begin
            put_byte(CH_NL);
            flush_line(1'b0, spent);
        end else if (ending == 7) begin
            put_byte(CH_SPACE); put_byte(CH_NL);
            flush_line(1'b0, spent);
        end else if (ending == 8) begin
            put_byte(CH_CR); put_byte(CH_NL);
            flush_line(1'b0, spent);
        end else if (ending == 9) begin
            flush_line(1'b1, spent);
        end else if (ending == 10) begin
            put_byte(CH_SPACE);
            flush_line(1'b1, spent);
        end else begin
            put_byte(CH_NL);
            flush_line($urandom_range(0, 1) != 0, spent);
        end
    endtask

    task automatic random_chunk(input int budget);
        int spent;
        int r;
        int n;
        spent = 0;
        while (spent < budget) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                face_line(spent);
            end else if (r < 8) begin
                // lines the block only skips
                case ($urandom_range(0, 4))
                    0: put_text("v 1.5 -2 3");
                    1: put_text("# fan");
                    2: put_text("vn 0 1 0");
                    3: put_text("g part");
                    default: ;
                endcase
                put_byte(CH_NL);
                flush_line($urandom_range(0, 15) == 0, spent);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) put_byte(CH_NL);
                flush_line($urandom_range(0, 3) == 0, spent);
            end
        end
    endtask

    // ---------------- test sequence ----------------
    initial begin
        int spent;
        spent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // byte extremes on a skipped line, CR and junk tokens, a short face,
        // and a final space that completes a triangle at stream end
        put_byte(8'h00); put_byte(8'hFF); put_byte(CH_NL);
        flush_line(1'b0, spent);
        put_text("f "); put_byte(CH_CR); put_text("0 x -1"); put_byte(CH_NL);
        flush_line(1'b0, spent);
        put_text("f 5 6"); put_byte(CH_NL);
        flush_line(1'b0, spent);
        put_text("f 1 2 3 ");
        flush_line(1'b1, spent);
        drain();

        // receiver holds off while a long face goes in, so the block backs up
        rx_hold_ask++;
        put_text("f");
        for (int k = 0; k < 40; k++) begin
            put_byte(CH_SPACE);
            put_number($urandom_range(1, 500));
        end
        put_byte(CH_NL);
        flush_line(1'b0, spent);
        drain();

        // token cap: tokens past the limit collapse into one trailing token
        put_text("f");
        for (int k = 0; k < MAX_CORNERS + 4; k++) begin
            put_byte(CH_SPACE);
            if (k == MAX_CORNERS - 2) begin
                put_byte(CH_SPACE);
                put_byte(CH_TAB);
            end
            put_number($urandom_range(1, 9));
        end
        put_byte(CH_NL);
        flush_line(1'b0, spent);

        random_chunk(800);
        drain();
        @(posedge i_clk);
        calm_tail = 1'b1;
        random_chunk(100);
        drain();

        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("** obj_face_fan_triangulator_unit: PASSED **");
        else
            $display("** obj_face_fan_triangulator_unit: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** obj_face_fan_triangulator_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ofan_pkg.sv
hdl/ofan_front.sv
hdl/ofan_back.sv
hdl/obj_face_fan_triangulator_unit.sv
tb/testbench.sv
